@@ hw/rtl/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, constants and character-class functions for the tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned PosBits = 24;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  typedef enum logic [2:0] {
    KIND_EOF     = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_STRING  = 3'd3,
    KIND_CHAR    = 3'd4,
    KIND_PUNCT   = 3'd5,
    KIND_PREPROC = 3'd6
  } tok_kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'd0,
    MODE_LCOM     = 4'd1,
    MODE_BC_OPEN  = 4'd2,
    MODE_BC       = 4'd3,
    MODE_BC_CLOSE = 4'd4,
    MODE_PP       = 4'd5,
    MODE_PP_SKIP2 = 4'd6,
    MODE_PP_SKIP1 = 4'd7,
    MODE_QOPEN2   = 4'd8,
    MODE_QOPEN1   = 4'd9,
    MODE_QBODY    = 4'd10,
    MODE_IDENT    = 4'd11,
    MODE_NUM      = 4'd12,
    MODE_PSKIP3   = 4'd13,
    MODE_PSKIP2   = 4'd14,
    MODE_PSKIP1   = 4'd15
  } lex_mode_e;

  typedef struct packed {
    tok_kind_e          kind;
    logic [PosBits-1:0] offset;
    logic [PosBits-1:0] length;
    logic [PosBits-1:0] line;
    logic [PosBits-1:0] column;
  } tok_t;

  typedef struct packed {
    lex_mode_e          mode;
    logic               quote_sq;
    logic               esc;
    logic               expo;
    logic [PosBits-1:0] offset;
    logic [PosBits-1:0] line;
    logic [PosBits-1:0] column;
    logic [PosBits-1:0] start;
    logic [PosBits-1:0] start_line;
    logic [PosBits-1:0] start_column;
  } lex_state_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_ident_cont(input logic [7:0] c);
    return c == 8'h5f || is_alnum(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a || c == 8'h0c || c == 8'h0b;
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return c == 8'h22 || c == 8'h27;
  endfunction

  function automatic logic [PosBits-1:0] sat_inc(input logic [PosBits-1:0] v);
    return (v == PosMax) ? v : v + PosBits'(1);
  endfunction

  function automatic logic is_two_op(input logic [7:0] c, input logic [7:0] d);
    logic r;
    r = 1'b0;
    unique case (c)
      8'h2d: r = d == 8'h3e || d == 8'h2d || d == 8'h3d;            // - > - =
      8'h2b: r = d == 8'h2b || d == 8'h3d;
      8'h3c: r = d == 8'h3c || d == 8'h3d || d == 8'h3a || d == 8'h25;
      8'h3e: r = d == 8'h3e || d == 8'h3d;
      8'h3d: r = d == 8'h3d;
      8'h21: r = d == 8'h3d;
      8'h26: r = d == 8'h26 || d == 8'h3d;
      8'h7c: r = d == 8'h7c || d == 8'h3d;
      8'h2a: r = d == 8'h3d;
      8'h2f: r = d == 8'h3d;
      8'h25: r = d == 8'h3d || d == 8'h3e || d == 8'h3a;
      8'h5e: r = d == 8'h3d;
      8'h23: r = d == 8'h23;
      8'h3a: r = d == 8'h3e;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] punct_len(input logic [7:0] c, input logic [7:0] l1,
                                           input logic [7:0] l2, input logic [7:0] l3);
    logic [2:0] r;
    if (c == 8'h25 && l1 == 8'h3a && l2 == 8'h25 && l3 == 8'h3a) r = 3'd4;
    else if ((c == 8'h2e && l1 == 8'h2e && l2 == 8'h2e) ||
             (c == 8'h3c && l1 == 8'h3c && l2 == 8'h3d) ||
             (c == 8'h3e && l1 == 8'h3e && l2 == 8'h3d)) r = 3'd3;
    else if (is_two_op(c, l1)) r = 3'd2;
    else r = 3'd1;
    return r;
  endfunction

endpackage

@@ hw/rtl/c_source_tokenizer.sv @@
// ----------------------------------------------------------------------------
// c_source_tokenizer
// Byte-stream C lexer with a four-byte lookahead window.
// ----------------------------------------------------------------------------
// Output: tokens are written into a registered queue and leave from its head.
// Throughput: one byte per cycle while stall_o is low; an end of input drains
// the window through four chained step units and emits up to five records from
// a small queue, one per cycle while stall_i is low, as further bytes are held off.
// Reset: asynchronous, active low; window empty, counters at offset 0, line 1.
module c_source_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  src_byte_i,
  input  logic        in_last_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [2:0]  tok_kind_o,
  output logic [23:0] tok_offset_o,
  output logic [23:0] tok_length_o,
  output logic [23:0] tok_line_o,
  output logic [23:0] tok_column_o,
  output logic        run_end_o
);

  localparam int unsigned QDepth = 5;

  logic [3:0][7:0]     win_q, win_d;
  logic [2:0]          fill_q, fill_d;
  cst_pkg::lex_state_t st_q, st_d;

  cst_pkg::tok_t [QDepth-1:0] q_tok_q, q_tok_d;
  logic [QDepth-1:0]          q_end_q, q_end_d;
  logic [2:0]                 q_cnt_q, q_cnt_d;

  logic in_acc, out_acc, fin_in;
  logic [7:0][7:0] ext;
  cst_pkg::lex_state_t [4:0] sc;
  logic [3:0] tv;
  cst_pkg::tok_t [3:0] tk;
  logic [3:0] use_u;
  cst_pkg::tok_t [QDepth-1:0] nt;
  logic [QDepth-1:0] ne;
  logic [2:0] nn;
  logic [2:0] base;
  cst_pkg::lex_state_t rst_st;

  assign stall_o = q_cnt_q > 3'd1 || (q_cnt_q == 3'd1 && stall_i);
  assign in_acc  = valid_i && !stall_o;
  assign out_acc = valid_o && !stall_i;
  assign fin_in  = src_byte_i == 8'h00 || in_last_i;

  always_comb begin
    rst_st = '0;
    rst_st.mode = cst_pkg::MODE_IDLE;
    rst_st.line = cst_pkg::PosBits'(1);
    rst_st.column = cst_pkg::PosBits'(1);
    rst_st.start_line = cst_pkg::PosBits'(1);
    rst_st.start_column = cst_pkg::PosBits'(1);
  end

  // window after appending the new byte, zero padded
  logic [2:0] f1;
  always_comb begin
    ext = '0;
    for (int i = 0; i < 4; i++) if (3'(i) < fill_q) ext[i] = win_q[i];
    f1 = fill_q;
    if (src_byte_i != 8'h00) begin
      ext[fill_q] = src_byte_i;
      f1 = fill_q + 3'd1;
    end
    // step u takes ext[u] below f1 when ending, else only step 0 and only when full
    for (int u = 0; u < 4; u++)
      use_u[u] = (3'(u) < f1) && (f1 == 3'd4 ? (u == 0 || fin_in) : fin_in);
  end

  assign sc[0] = st_q;
  for (genvar u = 0; u < 4; u++) begin : g_step
    logic [7:0] a1, a2, a3;
    cst_pkg::lex_state_t so;
    assign a1 = (3'(u + 1) < f1) ? ext[u+1] : 8'h00;
    assign a2 = (3'(u + 2) < f1) ? ext[u+2] : 8'h00;
    assign a3 = (3'(u + 3) < f1) ? ext[u+3] : 8'h00;
    cst_step u_step (
      .st_i(sc[u]), .c_i(ext[u]), .l1_i(a1), .l2_i(a2), .l3_i(a3),
      .st_o(so), .tok_vld_o(tv[u]), .tok_o(tk[u])
    );
    assign sc[u+1] = use_u[u] ? so : sc[u];
  end

  always_comb begin
    nt = '0;
    ne = '0;
    nn = '0;
    for (int u = 0; u < 4; u++) begin
      if (use_u[u] && tv[u]) begin
        nt[nn] = tk[u];
        nn = nn + 3'd1;
      end
    end
    if (fin_in) begin
      nt[nn].kind = cst_pkg::KIND_EOF;
      nt[nn].offset = sc[4].offset;
      nt[nn].length = '0;
      nt[nn].line = sc[4].line;
      nt[nn].column = sc[4].column;
      nn = nn + 3'd1;
    end
    if (nn != 3'd0) ne[nn - 3'd1] = 1'b1;
  end

  always_comb begin
    win_d = win_q;
    fill_d = fill_q;
    st_d = st_q;
    if (in_acc) begin
      if (fin_in) begin
        win_d = '0;
        fill_d = '0;
        st_d = rst_st;
      end else if (f1 == 3'd4) begin
        win_d = {8'h00, ext[3], ext[2], ext[1]};
        fill_d = 3'd3;
        st_d = sc[4];
      end else begin
        win_d = ext[3:0];
        fill_d = f1;
      end
    end
    q_tok_d = q_tok_q;
    q_end_d = q_end_q;
    base = q_cnt_q;
    if (out_acc) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_tok_d[i] = q_tok_q[i+1];
        q_end_d[i] = q_end_q[i+1];
      end
      base = q_cnt_q - 3'd1;
    end
    q_cnt_d = base;
    if (in_acc) begin
      for (int i = 0; i < QDepth; i++) begin
        if (3'(i) < nn) begin
          q_tok_d[base + 3'(i)] = nt[i];
          q_end_d[base + 3'(i)] = ne[i];
        end
      end
      q_cnt_d = base + nn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      fill_q <= '0;
      st_q <= rst_st;
      q_cnt_q <= '0;
    end else begin
      win_q <= win_d;
      fill_q <= fill_d;
      st_q <= st_d;
      q_cnt_q <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_tok_q <= q_tok_d;
    q_end_q <= q_end_d;
  end

  assign valid_o      = q_cnt_q != 3'd0;
  assign tok_kind_o   = q_tok_q[0].kind;
  assign tok_offset_o = q_tok_q[0].offset;
  assign tok_length_o = q_tok_q[0].length;
  assign tok_line_o   = q_tok_q[0].line;
  assign tok_column_o = q_tok_q[0].column;
  assign run_end_o    = q_end_q[0];

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) q_cnt_q <= 3'd5)
    else $error("queue overflow");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= 3'd3)
    else $error("window overfull");
  a_nostall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q == 3'd0 |-> !stall_o) else $error("stalled while empty");

endmodule

@@ hw/rtl/cst_step.sv @@
// ----------------------------------------------------------------------------
// cst_step
// Lexer state update for one byte leaving the window; gives at most one token.
// ----------------------------------------------------------------------------
module cst_step (
  input  cst_pkg::lex_state_t st_i,
  input  logic [7:0]          c_i,
  input  logic [7:0]          l1_i,
  input  logic [7:0]          l2_i,
  input  logic [7:0]          l3_i,
  output cst_pkg::lex_state_t st_o,
  output logic                tok_vld_o,
  output cst_pkg::tok_t       tok_o
);

  logic [2:0] plen;
  logic       fin;
  logic       done;
  logic       more;
  cst_pkg::tok_kind_e fkind;
  cst_pkg::lex_state_t s;

  assign plen = cst_pkg::punct_len(c_i, l1_i, l2_i, l3_i);

  always_comb begin
    s = st_i;
    fin = 1'b0;
    fkind = cst_pkg::KIND_PUNCT;
    tok_vld_o = 1'b0;
    done = 1'b0;
    more = 1'b0;
    tok_o = '0;
    // advance
    st_o = st_i;
    s.offset = cst_pkg::sat_inc(st_i.offset);
    if (c_i == 8'h0a) begin
      s.line = cst_pkg::sat_inc(st_i.line);
      s.column = cst_pkg::PosBits'(1);
    end else begin
      s.column = cst_pkg::sat_inc(st_i.column);
    end
    unique case (st_i.mode)
      cst_pkg::MODE_LCOM: if (c_i == 8'h0a) s.mode = cst_pkg::MODE_IDLE;
      cst_pkg::MODE_BC_OPEN: s.mode = cst_pkg::MODE_BC;
      cst_pkg::MODE_BC: if (c_i == 8'h2a && l1_i == 8'h2f) s.mode = cst_pkg::MODE_BC_CLOSE;
      cst_pkg::MODE_BC_CLOSE: s.mode = cst_pkg::MODE_IDLE;
      cst_pkg::MODE_PP_SKIP2: s.mode = cst_pkg::MODE_PP_SKIP1;
      cst_pkg::MODE_PP_SKIP1: begin
        s.mode = cst_pkg::MODE_PP;
        if (l1_i == 8'h0a || l1_i == 8'h00) begin
          fin = 1'b1;
          fkind = cst_pkg::KIND_PREPROC;
        end
      end
      cst_pkg::MODE_QOPEN2: s.mode = cst_pkg::MODE_QOPEN1;
      cst_pkg::MODE_QOPEN1: begin
        s.esc = 1'b0;
        s.mode = cst_pkg::MODE_QBODY;
        if (l1_i == 8'h00) begin
          fin = 1'b1;
          fkind = st_i.quote_sq ? cst_pkg::KIND_CHAR : cst_pkg::KIND_STRING;
        end
      end
      cst_pkg::MODE_QBODY: begin
        if (st_i.esc) begin
          s.esc = 1'b0;
          done = l1_i == 8'h00;
        end else if (c_i == 8'h5c && l1_i != 8'h00) begin
          s.esc = 1'b1;
        end else begin
          done = (c_i == (st_i.quote_sq ? 8'h27 : 8'h22)) || l1_i == 8'h00;
        end
        if (done) begin
          s.esc = 1'b0;
          fin = 1'b1;
          fkind = st_i.quote_sq ? cst_pkg::KIND_CHAR : cst_pkg::KIND_STRING;
        end
      end
      cst_pkg::MODE_IDENT: if (!cst_pkg::is_ident_cont(l1_i)) begin
        fin = 1'b1;
        fkind = cst_pkg::KIND_IDENT;
      end
      cst_pkg::MODE_NUM: begin
        if (cst_pkg::is_alnum(c_i) || c_i == 8'h2e || c_i == 8'h5f)
          s.expo = c_i == 8'h65 || c_i == 8'h45 || c_i == 8'h70 || c_i == 8'h50;
        else
          s.expo = 1'b0;
        more = cst_pkg::is_alnum(l1_i) || l1_i == 8'h2e || l1_i == 8'h5f ||
               ((l1_i == 8'h2b || l1_i == 8'h2d) && s.expo);
        if (!more) begin
          fin = 1'b1;
          fkind = cst_pkg::KIND_NUMBER;
        end
      end
      cst_pkg::MODE_PSKIP3: s.mode = cst_pkg::MODE_PSKIP2;
      cst_pkg::MODE_PSKIP2: s.mode = cst_pkg::MODE_PSKIP1;
      cst_pkg::MODE_PSKIP1: s.mode = cst_pkg::MODE_IDLE;
      cst_pkg::MODE_PP: begin
        if (c_i == 8'h5c && l1_i == 8'h0d && l2_i == 8'h0a) s.mode = cst_pkg::MODE_PP_SKIP2;
        else if (c_i == 8'h5c && l1_i == 8'h0a) s.mode = cst_pkg::MODE_PP_SKIP1;
        else if (l1_i == 8'h0a || l1_i == 8'h00) begin
          fin = 1'b1;
          fkind = cst_pkg::KIND_PREPROC;
        end
      end
      default: begin
        if (cst_pkg::is_space(c_i)) begin
        end else if (c_i == 8'h2f && (l1_i == 8'h2f || l1_i == 8'h2a)) begin
          s.mode = (l1_i == 8'h2f) ? cst_pkg::MODE_LCOM : cst_pkg::MODE_BC_OPEN;
        end else begin
          s.start = st_i.offset;
          s.start_line = st_i.line;
          s.start_column = st_i.column;
          if (c_i == 8'h23) begin
            s.mode = cst_pkg::MODE_PP;
            if (c_i == 8'h5c && l1_i == 8'h0a) s.mode = cst_pkg::MODE_PP_SKIP1;
            else if (l1_i == 8'h0a || l1_i == 8'h00) begin
              fin = 1'b1;
              fkind = cst_pkg::KIND_PREPROC;
            end
          end else if ((c_i == 8'h4c || c_i == 8'h75 || c_i == 8'h55) &&
                       cst_pkg::is_quote(l1_i)) begin
            s.quote_sq = l1_i == 8'h27;
            s.mode = cst_pkg::MODE_QOPEN1;
          end else if (c_i == 8'h75 && l1_i == 8'h38 && cst_pkg::is_quote(l2_i)) begin
            s.quote_sq = l2_i == 8'h27;
            s.mode = cst_pkg::MODE_QOPEN2;
          end else if (c_i == 8'h5f || cst_pkg::is_alpha(c_i)) begin
            s.mode = cst_pkg::MODE_IDENT;
            if (!cst_pkg::is_ident_cont(l1_i)) begin
              fin = 1'b1;
              fkind = cst_pkg::KIND_IDENT;
            end
          end else if (cst_pkg::is_digit(c_i) || (c_i == 8'h2e && cst_pkg::is_digit(l1_i)))
          begin
            s.expo = 1'b0;
            s.mode = cst_pkg::MODE_NUM;
            more = cst_pkg::is_alnum(l1_i) || l1_i == 8'h2e || l1_i == 8'h5f;
            if (!more) begin
              fin = 1'b1;
              fkind = cst_pkg::KIND_NUMBER;
            end
          end else if (cst_pkg::is_quote(c_i)) begin
            s.quote_sq = c_i == 8'h27;
            s.esc = 1'b0;
            s.mode = cst_pkg::MODE_QBODY;
            if (l1_i == 8'h00) begin
              fin = 1'b1;
              fkind = (c_i == 8'h27) ? cst_pkg::KIND_CHAR : cst_pkg::KIND_STRING;
            end
          end else begin
            tok_vld_o = 1'b1;
            tok_o.kind = cst_pkg::KIND_PUNCT;
            tok_o.offset = st_i.offset;
            tok_o.length = cst_pkg::PosBits'(plen);
            tok_o.line = st_i.line;
            tok_o.column = st_i.column;
            unique case (plen)
              3'd4: s.mode = cst_pkg::MODE_PSKIP3;
              3'd3: s.mode = cst_pkg::MODE_PSKIP2;
              3'd2: s.mode = cst_pkg::MODE_PSKIP1;
              default: s.mode = cst_pkg::MODE_IDLE;
            endcase
          end
        end
      end
    endcase
    if (fin) begin
      tok_vld_o = 1'b1;
      tok_o.kind = fkind;
      tok_o.offset = s.start;
      tok_o.length = s.offset - s.start;
      tok_o.line = s.start_line;
      tok_o.column = s.start_column;
      s.mode = cst_pkg::MODE_IDLE;
    end
    st_o = s;
  end

endmodule
